FILE: design/three_level_stable_priority_queue_core_assert.svh
// Assertion macros used by the queue's control module.
`ifndef THREE_LEVEL_STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define THREE_LEVEL_STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLSPQ_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tlspq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TLSPQ_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tlspq assertion failed");

`endif

FILE: design/tlspq_pkg.sv
package tlspq_pkg;

  localparam int ID_W     = 37;
  localparam int ITEMS_W  = 10;
  localparam int LEVEL_W  = 2;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;
  localparam int LIDX_W   = 2;

  localparam int DEFAULT_DEPTH = 16;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SERVE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_SERVED   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BADLEVEL = 3'd4;

  localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 2'd1;

  localparam logic [LIDX_W-1:0] LIDX_HIGH = 2'd0;
  localparam logic [LIDX_W-1:0] LIDX_MID  = 2'd1;
  localparam logic [LIDX_W-1:0] LIDX_LOW  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ITEMS_W-1:0] items;
  } entry_t;

endpackage

FILE: design/tlspq_req_if.sv
interface tlspq_req_if import tlspq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [LEVEL_W-1:0] level;
  logic [ID_W-1:0]    customer_id;
  logic [ITEMS_W-1:0] item_count;

  modport source (output valid, output req_type, output level, output customer_id,
                  output item_count, input ready);
  modport sink (input valid, input req_type, input level, input customer_id,
                input item_count, output ready);
endinterface

FILE: design/tlspq_rsp_if.sv
interface tlspq_rsp_if import tlspq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     served_id;
  logic [ITEMS_W-1:0]  served_items;
  logic [LEVEL_W-1:0]  served_level;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output served_id, output served_items,
                  output served_level, output occupancy, input ready);
  modport sink (input valid, input status, input served_id, input served_items,
                input served_level, input occupancy, output ready);
endinterface

FILE: design/three_level_stable_priority_queue_core.sv
// Channel  Role    Payload
// req      sink    req_type, level, customer_id, item_count
// rsp      source  status, served_id, served_items, served_level, occupancy
//
// An insert or a refused request gives its result in the cycle after its transfer.
// A serve of a non-empty queue registers the entry memory's read data, then the result.
// A new request is taken once the previous result is registered and the output is free or
// being taken in the same cycle.
// Reset empties all three level queues at once; the entry memory itself is not cleared.
module three_level_stable_priority_queue_core import tlspq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input logic         clk,
  input logic         rst,
  tlspq_req_if.sink   req,
  tlspq_rsp_if.source rsp
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = PTR_W + LIDX_W;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  entry_t            mem_rdata;

  tlspq_ctrl #(
    .DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tlspq_store #(
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: design/tlspq_store.sv
module tlspq_store import tlspq_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int ADDR_W = PTR_W + LIDX_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  // One circular buffer of DEPTH words per level, selected by the upper address bits.
  localparam int WORDS = 3 * (1 << PTR_W);

  entry_t mem [0:WORDS-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/tlspq_ctrl.sv
`include "three_level_stable_priority_queue_core_assert.svh"

module tlspq_ctrl import tlspq_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int ADDR_W = PTR_W + LIDX_W
) (
  input  logic              clk,
  input  logic              rst,
  tlspq_req_if.sink         req,
  tlspq_rsp_if.source       rsp,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output entry_t            mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  entry_t            mem_rdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] cnt  [0:2];
  logic [PTR_W-1:0] head [0:2];
  logic [PTR_W-1:0] tail [0:2];
  logic [LEVEL_W-1:0] srv_level;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_id;
  logic [ITEMS_W-1:0]  out_items;
  logic [LEVEL_W-1:0]  out_level;
  logic [OCC_W-1:0]    out_occ;

  logic              acc;
  logic              is_ins;
  logic              bad;
  logic              full;
  logic              ins_ok;
  logic              srv_ok;
  logic [LIDX_W-1:0] lidx;
  logic [LIDX_W-1:0] sel;
  logic [PTR_W-1:0]  tail_cur;
  logic [PTR_W-1:0]  head_cur;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);

  always_comb begin
    acc    = req.valid && req.ready;
    is_ins = req.req_type == REQ_INSERT;
    bad    = req.level == LEVEL_NONE;
    full   = total == CNT_W'(DEPTH);
    lidx   = LIDX_W'(req.level - LEVEL_ONE);
    ins_ok = acc && is_ins && !bad && !full;
    srv_ok = acc && !is_ins && (total != '0);
    if (cnt[0] != '0) begin
      sel = LIDX_HIGH;
    end else if (cnt[1] != '0) begin
      sel = LIDX_MID;
    end else begin
      sel = LIDX_LOW;
    end
    case (lidx)
      LIDX_HIGH: tail_cur = tail[0];
      LIDX_MID:  tail_cur = tail[1];
      default:   tail_cur = tail[2];
    endcase
    case (sel)
      LIDX_HIGH: head_cur = head[0];
      LIDX_MID:  head_cur = head[1];
      default:   head_cur = head[2];
    endcase
  end

  assign mem_we          = ins_ok;
  assign mem_waddr       = {lidx, tail_cur};
  assign mem_wdata.id    = req.customer_id;
  assign mem_wdata.items = req.item_count;
  assign mem_re          = srv_ok;
  assign mem_raddr       = {sel, head_cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      for (int i = 0; i < 3; i++) begin
        cnt[i]  <= '0;
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (is_ins) begin
              out_valid <= 1'b1;
              out_id    <= '0;
              out_items <= '0;
              out_level <= LEVEL_NONE;
              if (bad) begin
                out_status <= STATUS_BADLEVEL;
                out_occ    <= OCC_W'(total);
              end else if (full) begin
                out_status <= STATUS_FULL;
                out_occ    <= OCC_W'(total);
              end else begin
                out_status <= STATUS_INSERTED;
                out_occ    <= OCC_W'(total + CNT_W'(1));
                tail[lidx] <= ptr_inc(tail_cur);
                cnt[lidx]  <= cnt[lidx] + CNT_W'(1);
                total      <= total + CNT_W'(1);
              end
            end else if (total == '0) begin
              out_valid  <= 1'b1;
              out_status <= STATUS_EMPTY;
              out_id     <= '0;
              out_items  <= '0;
              out_level  <= LEVEL_NONE;
              out_occ    <= OCC_W'(total);
            end else begin
              out_valid <= 1'b0;
              head[sel] <= ptr_inc(head_cur);
              cnt[sel]  <= cnt[sel] - CNT_W'(1);
              total     <= total - CNT_W'(1);
              srv_level <= LEVEL_W'(sel) + LEVEL_ONE;
              state     <= S_READ;
            end
          end else if (rsp.valid && rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          out_valid  <= 1'b1;
          out_status <= STATUS_SERVED;
          out_id     <= mem_rdata.id;
          out_items  <= mem_rdata.items;
          out_level  <= srv_level;
          out_occ    <= OCC_W'(total);
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.served_id    = out_id;
  assign rsp.served_items = out_items;
  assign rsp.served_level = out_level;
  assign rsp.occupancy    = out_occ;

  `TLSPQ_ASSERT_IMP(a_total_bound, clk, rst, 1'b1, total <= CNT_W'(DEPTH))
  `TLSPQ_ASSERT_IMP(a_total_sum, clk, rst, 1'b1, total == cnt[0] + cnt[1] + cnt[2])
  `TLSPQ_ASSERT_NXT(a_serve_read, clk, rst, srv_ok, state == S_READ)
  `TLSPQ_ASSERT_NXT(a_read_result, clk, rst, state == S_READ,
                    out_valid && out_status == STATUS_SERVED)

endmodule
